// File: design/blnw_pkg.sv
// Shared types and constants for the buffered LCD nibble writer.
`timescale 1ns / 1ps
package blnw_pkg;

  localparam int unsigned DATA_DEPTH_DEF = 32;

  typedef enum logic [1:0] {
    OP_QUEUE = 2'd0,
    OP_CMD   = 2'd1,
    OP_TICK  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CMD_HI,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] byte_value;
  } req_beat_t;

  typedef struct packed {
    logic [3:0] nibble;
    logic       register_select;
    logic       strobe_res;
    logic       status;
    logic       last;
  } rsp_beat_t;

endpackage

// File: design/blnw_ram.sv
// Generic simple dual-port RAM, one write port, one registered read port.
`timescale 1ns / 1ps
module blnw_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/buffered_lcd_nibble_writer_top.sv
// Buffered 4-bit character LCD writer: data queue, command bypass, tick dispatcher.
//
//   channel | dir | handshake            | payload
//   req     | in  | req_valid/req_stall  | req_beat_t (operation, byte_value)
//   rsp     | out | rsp_valid/rsp_stall  | rsp_beat_t (nibble, rs, strobe, status, last)
//
// One item at a time. Queue: accepted in ST_IDLE, answered from ST_OUT, then back to idle.
// Tick: passes ST_READ, which uses the registered read of the data RAM, then ST_OUT.
// Command: upper nibble beat in ST_CMD_HI, lower in ST_OUT, through the single output register.
// Output stalls hold the current beat and keep req stalled.
// Reset clears indices, phase and the per-entry valid bits at once; no clearing pass.
`timescale 1ns / 1ps
module buffered_lcd_nibble_writer_top
  import blnw_pkg::*;
#(
  parameter int unsigned DATA_DEPTH = DATA_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  input  req_beat_t req,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output rsp_beat_t rsp
);

  localparam int unsigned AW = $clog2(DATA_DEPTH);
  localparam int unsigned IW = $clog2(DATA_DEPTH + 1);
  localparam logic [IW-1:0] DEPTH_I = IW'(DATA_DEPTH);

  state_t                state, state_next;
  rsp_beat_t             rsp_next;
  logic [IW-1:0]         write_index, write_index_next;
  logic [IW-1:0]         read_index, read_index_next;
  logic                  lower_phase, lower_phase_next;
  logic [3:0]            cmd_low;
  logic [DATA_DEPTH-1:0] entry_valid;

  logic                  wr_en, clr_en, req_fire, full, in_range, hit;
  logic [7:0]            rdata;
  logic [AW-1:0]         waddr, raddr;
  logic [3:0]            tick_nib;

  assign req_fire = req_valid && !req_stall;
  assign waddr    = write_index[AW-1:0];
  assign raddr    = read_index[AW-1:0];
  assign full     = (write_index >= DEPTH_I);
  assign in_range = (read_index < DEPTH_I);
  // an entry never written since reset, or consumed, counts as a zero byte (no hit)
  assign hit      = in_range && entry_valid[raddr] && (rdata != 8'd0);
  assign tick_nib = lower_phase ? rdata[3:0] : rdata[7:4];

  blnw_ram #(
    .WIDTH(8),
    .DEPTH(DATA_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (wr_en),
    .waddr(waddr),
    .wdata(req.byte_value),
    .raddr(raddr),
    .rdata(rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          case (req.operation)
            OP_QUEUE: state_next = ST_OUT;
            OP_CMD:   state_next = ST_CMD_HI;
            OP_TICK:  state_next = ST_READ;
            default:  state_next = ST_IDLE;
          endcase
        end
      end
      ST_READ:   state_next = ST_OUT;
      ST_CMD_HI: if (!rsp_stall) state_next = ST_OUT;
      ST_OUT:    if (!rsp_stall) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // outputs and datapath updates
  always_comb begin
    req_stall        = (state != ST_IDLE);
    rsp_valid        = (state == ST_CMD_HI) || (state == ST_OUT);
    rsp_next         = rsp;
    wr_en            = 1'b0;
    clr_en           = 1'b0;
    write_index_next = write_index;
    read_index_next  = read_index;
    lower_phase_next = lower_phase;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          case (req.operation)
            OP_QUEUE: begin
              wr_en            = !full;
              write_index_next = full ? write_index : write_index + IW'(1);
              rsp_next         = '{4'd0, 1'b0, 1'b0, full, 1'b1};
            end
            OP_CMD: begin
              rsp_next = '{req.byte_value[7:4], 1'b0, 1'b1, 1'b0, 1'b0};
            end
            default: ;
          endcase
        end
      end
      ST_READ: begin
        if (hit) begin
          rsp_next = '{tick_nib, 1'b1, 1'b1, 1'b0, 1'b1};
          if (lower_phase) begin
            clr_en           = 1'b1;
            read_index_next  = read_index + IW'(1);
            lower_phase_next = 1'b0;
          end else begin
            lower_phase_next = 1'b1;
          end
        end else begin
          // end mark (zero byte or invalid entry) or end of buffer: rewind both indices
          write_index_next = '0;
          read_index_next  = '0;
          rsp_next         = '{4'd0, 1'b0, 1'b0, 1'b0, 1'b1};
        end
      end
      ST_CMD_HI: begin
        if (!rsp_stall) begin
          rsp_next = '{cmd_low, 1'b0, 1'b1, 1'b0, 1'b1};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      write_index <= '0;
      read_index  <= '0;
      lower_phase <= 1'b0;
      entry_valid <= '0;
    end else begin
      state       <= state_next;
      write_index <= write_index_next;
      read_index  <= read_index_next;
      lower_phase <= lower_phase_next;
      if (wr_en) begin
        entry_valid[waddr] <= 1'b1;
      end
      if (clr_en) begin
        entry_valid[raddr] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rsp <= rsp_next;
    if (req_fire) begin
      cmd_low <= req.byte_value[3:0];
    end
  end

  a_windex_bound: assert property (@(posedge clk) disable iff (rst)
    write_index <= DEPTH_I)
    else $error("write index past buffer depth");

  a_rindex_bound: assert property (@(posedge clk) disable iff (rst)
    read_index <= DEPTH_I)
    else $error("read index past buffer depth");

  a_phase_in_range: assert property (@(posedge clk) disable iff (rst)
    lower_phase |-> in_range)
    else $error("lower nibble pending with read index out of range");

  a_cmd_pair: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CMD_HI && !rsp_stall) |=> (rsp_valid && rsp.last && rsp.strobe_res))
    else $error("command upper nibble not followed by final lower nibble");

  a_nonlast_is_cmd: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp.last) |-> (rsp.strobe_res && !rsp.register_select))
    else $error("non-final beat that is not a command nibble");

endmodule
